[hdl/pru_pkg.sv]
package pru_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FRAME_WIDTH     = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_SCALE_FACTOR    = 2'd2;
    localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd3;

    // field widths
    localparam int DIM_W   = 13;
    localparam int SCALE_W = 4;
    localparam int BPP_W   = 3;
    localparam int ADDR_W  = 32;
    localparam int PIX_W   = 32;

    // register reset values
    localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH     = 13'd640;
    localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT    = 13'd480;
    localparam logic [SCALE_W-1:0] RST_SCALE_FACTOR    = 4'd3;
    localparam logic [BPP_W-1:0]   RST_BYTES_PER_PIXEL = 3'd3;

    // raw register contents
    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [SCALE_W-1:0] scale_factor;
        logic [BPP_W-1:0]   bytes_per_pixel;
    } t_cfg;

    // one pixel's worth of work for the write generator
    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [ADDR_W-1:0]  row_step;
        logic [BPP_W-1:0]   bpp;
        logic [SCALE_W-1:0] scale;
        logic [PIX_W-1:0]   pixel;
        logic               frame_end;
    } t_job;

    // front to queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

endpackage

[hdl/pixel_replication_upscaler.sv]
// channel   | direction | signals                                    | moves
// ----------+-----------+--------------------------------------------+-------------------------
// pixel in  | in        | i_valid / o_ready, i_pixel_value           | one source pixel
// write out | out       | o_valid / i_ready, o_dest_*, o_last_of_*   | one frame buffer write
// config    | in        | i_cfg_we, i_cfg_index, i_cfg_data          | one register write
//
// each pixel gives scale*scale write requests, one per cycle from the write generator while i_ready is high
// the address front end runs each pixel through three chained multiply stages and a push
// it takes no new pixel until that push is accepted by the job queue
// a two-entry job queue lets the front end run ahead while output requests are stalled
// synchronous active-low reset: registers to 640x480, scale 3, 3 bytes, raster position zero
module pixel_replication_upscaler import pru_pkg::*; #(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int MAX_SCALE       = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [PIX_W-1:0]  i_pixel_value,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_dest_address,
    output logic [PIX_W-1:0]  o_dest_pixel,
    output logic              o_last_of_pixel,
    output logic              o_last_of_frame
);

    t_cfg  r_cfg;
    t_push push;
    logic  full, job_valid, pop;
    t_job  job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width     <= RST_FRAME_WIDTH;
            r_cfg.frame_height    <= RST_FRAME_HEIGHT;
            r_cfg.scale_factor    <= RST_SCALE_FACTOR;
            r_cfg.bytes_per_pixel <= RST_BYTES_PER_PIXEL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:     r_cfg.frame_width     <= i_cfg_data;
                REG_FRAME_HEIGHT:    r_cfg.frame_height    <= i_cfg_data;
                REG_SCALE_FACTOR:    r_cfg.scale_factor    <= i_cfg_data[SCALE_W-1:0];
                REG_BYTES_PER_PIXEL: r_cfg.bytes_per_pixel <= i_cfg_data[BPP_W-1:0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    // address front end
    pru_front #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .MAX_SCALE       (MAX_SCALE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .o_push        (push),
        .i_full        (full)
    );

    // job queue
    pru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (job_valid),
        .o_job   (job),
        .i_pop   (pop)
    );

    // write generator
    pru_back #(
        .MAX_SCALE (MAX_SCALE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_job           (job),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_dest_address  (o_dest_address),
        .o_dest_pixel    (o_dest_pixel),
        .o_last_of_pixel (o_last_of_pixel),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

[hdl/pru_front.sv]
module pru_front import pru_pkg::*; #(
    parameter int MAX_LINE_PIXELS = 4096,
    parameter int MAX_SCALE       = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel_value,
    output t_push            o_push,
    input  logic             i_full
);

    localparam int CW = $clog2(MAX_LINE_PIXELS);
    localparam int PW = $clog2(MAX_LINE_PIXELS + 1);
    localparam int SW = $clog2(MAX_SCALE + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL2 = 2'd1;
    localparam logic [1:0] ST_MUL3 = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_row, r_col;
    logic [CW+SW-1:0]    r_ys, r_xs;
    logic [PW+SW-1:0]    r_lp;
    logic [SW+2:0]       r_sm;
    logic [PIX_W-1:0]    r_pix;
    logic                r_fend;
    logic [SCALE_W-1:0]  r_s;
    logic [BPP_W-1:0]    r_b;
    logic [ADDR_W-1:0]   r_t, r_lb, r_base, r_step;

    logic [PW-1:0]       w_eff, h_eff;
    logic [SW-1:0]       s_eff;
    logic [BPP_W-1:0]    b_eff;
    logic [PIX_W-1:0]    mask;
    logic [SW+2:0]       sm;
    logic                end_col, end_row, accept;

    // saturate the registers into their legal ranges
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            w_eff = PW'(1);
        end else if (32'(i_cfg.frame_width) > 32'(MAX_LINE_PIXELS)) begin
            w_eff = PW'(MAX_LINE_PIXELS);
        end else begin
            w_eff = PW'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            h_eff = PW'(1);
        end else if (32'(i_cfg.frame_height) > 32'(MAX_LINE_PIXELS)) begin
            h_eff = PW'(MAX_LINE_PIXELS);
        end else begin
            h_eff = PW'(i_cfg.frame_height);
        end
        if (i_cfg.scale_factor == '0) begin
            s_eff = SW'(1);
        end else if (32'(i_cfg.scale_factor) > 32'(MAX_SCALE)) begin
            s_eff = SW'(MAX_SCALE);
        end else begin
            s_eff = SW'(i_cfg.scale_factor);
        end
        if (i_cfg.bytes_per_pixel == '0) begin
            b_eff = 3'd1;
        end else if (i_cfg.bytes_per_pixel > 3'd4) begin
            b_eff = 3'd4;
        end else begin
            b_eff = i_cfg.bytes_per_pixel;
        end
    end

    // byte mask for the pixel
    always_comb begin
        case (b_eff)
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    // line and frame end, counter at or past the last place counts as last
    assign end_col = 32'(r_col) >= (32'(w_eff) - 32'd1);
    assign end_row = 32'(r_row) >= (32'(h_eff) - 32'd1);
    assign sm      = (SW+3)'(s_eff - SW'(1)) * (SW+3)'(b_eff);

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (accept) n_state = ST_MUL2;
            ST_MUL2: n_state = ST_MUL3;
            ST_MUL3: n_state = ST_PUSH;
            ST_PUSH: if (!i_full) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (end_col) begin
                    r_col <= '0;
                    r_row <= end_row ? '0 : r_row + CW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // address datapath, one level of chained multiplies per stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ys   <= (CW+SW)'(r_row) * (CW+SW)'(s_eff);
            r_xs   <= (CW+SW)'(r_col) * (CW+SW)'(s_eff);
            r_lp   <= (PW+SW)'(w_eff) * (PW+SW)'(s_eff);
            r_sm   <= sm;
            r_pix  <= i_pixel_value & mask;
            r_fend <= end_col && end_row;
            r_s    <= SCALE_W'(s_eff);
            r_b    <= b_eff;
        end
        if (r_state == ST_MUL2) begin
            r_t  <= 32'(r_ys) * 32'(r_lp) + 32'(r_xs);
            r_lb <= 32'(r_lp) * 32'(r_b);
        end
        if (r_state == ST_MUL3) begin
            r_base <= r_t * 32'(r_b);
            r_step <= r_lb - 32'(r_sm);
        end
    end

    // job to the queue
    always_comb begin
        o_push.valid         = (r_state == ST_PUSH);
        o_push.job.base      = r_base;
        o_push.job.row_step  = r_step;
        o_push.job.bpp       = r_b;
        o_push.job.scale     = r_s;
        o_push.job.pixel     = r_pix;
        o_push.job.frame_end = r_fend;
    end

endmodule

[hdl/pru_queue.sv]
module pru_queue import pru_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output logic  o_valid,
    output t_job  o_job,
    input  logic  i_pop
);

    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       push, pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];
    assign push    = i_push.valid && !o_full;
    assign pop     = i_pop && o_valid;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= i_push.job;
    end

endmodule

[hdl/pru_back.sv]
module pru_back import pru_pkg::*; #(
    parameter int MAX_SCALE = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_dest_address,
    output logic [PIX_W-1:0]  o_dest_pixel,
    output logic              o_last_of_pixel,
    output logic              o_last_of_frame
);

    localparam int IW = $clog2(MAX_SCALE);

    logic                r_busy, r_out_valid;
    logic [IW-1:0]       r_i, r_j;
    logic [ADDR_W-1:0]   r_addr, r_step;
    logic [BPP_W-1:0]    r_b;
    logic [SCALE_W-1:0]  r_scale;
    logic [PIX_W-1:0]    r_pix;
    logic                r_fend;
    logic [ADDR_W-1:0]   r_out_addr;
    logic [PIX_W-1:0]    r_out_pix;
    logic                r_out_lp, r_out_lf;
    logic                adv, last_i, last_j, last;

    assign adv    = r_busy && (!r_out_valid || i_ready);
    assign last_i = (SCALE_W'(r_i) == r_scale - SCALE_W'(1));
    assign last_j = (SCALE_W'(r_j) == r_scale - SCALE_W'(1));
    assign last   = last_i && last_j;
    assign o_pop  = i_job_valid && (!r_busy || (adv && last));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // sub-row i major, sub-column j minor
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_i     <= '0;
            r_j     <= '0;
            r_addr  <= i_job.base;
            r_step  <= i_job.row_step;
            r_b     <= i_job.bpp;
            r_scale <= i_job.scale;
            r_pix   <= i_job.pixel;
            r_fend  <= i_job.frame_end;
        end else if (adv && !last) begin
            if (last_j) begin
                r_j    <= '0;
                r_i    <= r_i + IW'(1);
                r_addr <= r_addr + r_step;
            end else begin
                r_j    <= r_j + IW'(1);
                r_addr <= r_addr + 32'(r_b);
            end
        end
        if (adv) begin
            r_out_addr <= r_addr;
            r_out_pix  <= r_pix;
            r_out_lp   <= last;
            r_out_lf   <= last && r_fend;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_dest_address  = r_out_addr;
    assign o_dest_pixel    = r_out_pix;
    assign o_last_of_pixel = r_out_lp;
    assign o_last_of_frame = r_out_lf;

endmodule

[hdl/pru_checker.sv]
module pru_checker import pru_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              o_ready,
    input  logic [PIX_W-1:0]  i_pixel_value,
    input  logic              o_valid,
    input  logic              i_ready,
    input  logic [ADDR_W-1:0] o_dest_address,
    input  logic [PIX_W-1:0]  o_dest_pixel,
    input  logic              o_last_of_pixel,
    input  logic              o_last_of_frame
);

    // a stalled pixel request holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_pixel_value))
        else $error("pixel request changed while stalled");

    // a stalled write request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_dest_address) && $stable(o_dest_pixel)
            && $stable(o_last_of_pixel) && $stable(o_last_of_frame))
        else $error("write request changed while stalled");

    // frame end only on a pixel's final write
    a_frame_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_frame |-> o_last_of_pixel)
        else $error("frame end without pixel end");

    // reset empties the pipe and opens the input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");

endmodule

bind pixel_replication_upscaler pru_checker u_checker (.*);
